// ===== rtl/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU tag lookup.
// Used by the lookup top level and by its port checker; depends on nothing.
package salru_pkg;

    // Default geometry of the tag store.
    localparam int SETS_DEFAULT = 64;
    localparam int WAYS_DEFAULT = 4;

    // Field widths of the stream and configuration ports.
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int SET_IDX_W   = 6;
    localparam int WAY_OUT_W   = 2;
    localparam int OUT_DATA_W  = 40;  // set_index + tag + way, already whole bytes
    localparam int OFF_BITS_W  = 4;
    localparam int SET_BITS_W  = 3;
    localparam int CFG_DATA_W  = 4;

    // Limits and reset values of the configuration registers.
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_MAX   = 4'd12;
    localparam logic [SET_BITS_W-1:0] SET_BITS_MAX   = 3'd6;
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_RESET = 4'd6;
    localparam logic [SET_BITS_W-1:0] SET_BITS_RESET = 3'd6;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_OFFSET_BITS = 1'b0,
        REG_SET_BITS    = 1'b1
    } reg_idx_t;

endpackage

// ===== rtl/set_assoc_lru_tag_lookup.sv =====
// Pipeline: the row is read into the compare stage at the address transfer; the compare result is
// then loaded into the result register once that register is free or being emptied.
// Throughput: one address per cycle, sustained, as long as the result side keeps taking transfers.
// Back-to-back lookups to the same set are served by forwarding the last written row.
// Reset: configuration returns to offset_bits 6, set_bits 6; then a clearing pass over every set
// marks every way invalid and restores the default recency order, with s_tready held low.
// Depends on salru_pkg.
module set_assoc_lru_tag_lookup
    import salru_pkg::*;
#(
    parameter int SETS = SETS_DEFAULT,
    parameter int WAYS = WAYS_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  reg_idx_t              cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Address stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] address
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] set_index, [37:6] tag, [39:38] way
    output logic                  m_tuser    // [0] hit
);

    // Width of a way number and of a row address in the store.
    localparam int WB  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SIW = (SETS > 1) ? $clog2(SETS) : 1;
    // Largest k with 2^k <= SETS, then capped by the set field limit.
    localparam int SETS_LOG_FLOOR = $clog2(SETS + 1) - 1;
    localparam int SET_LIM_INT    = (SETS_LOG_FLOOR < 6) ? SETS_LOG_FLOOR : 6;
    localparam logic [SET_BITS_W-1:0] SET_LIM = SET_BITS_W'(SET_LIM_INT);

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [WAYS-1:0]            vld_row_t;
    typedef logic [WAYS-1:0][WB-1:0]    lru_row_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [OFF_BITS_W-1:0] offset_bits_reg;
    logic [SET_BITS_W-1:0] set_bits_reg;

    // ------------------------------------------------------------------
    // Tag store: one row per set holding the tags, valid bits and the
    // recency order (position 0 most recent). All three arrays share a
    // row address; each has one write and one registered read per cycle.
    // ------------------------------------------------------------------
    tag_row_t tag_mem [SETS];
    vld_row_t vld_mem [SETS];
    lru_row_t lru_mem [SETS];

    // Clearing pass after reset.
    logic           clr_busy_reg;
    logic [SIW-1:0] clr_cnt_reg;

    // Stage 1: the item whose row has just been read.
    logic                 s1_vld_reg;
    logic [SET_IDX_W-1:0] s1_set_reg;
    logic [TAG_W-1:0]     s1_tag_reg;
    tag_row_t             rd_tag_reg;
    vld_row_t             rd_vld_reg;
    lru_row_t             rd_lru_reg;

    // Copy of the most recent row write, forwarded to a following lookup
    // of the same set whose read happened before the write landed.
    logic           byp_vld_reg;
    logic [SIW-1:0] byp_set_reg;
    tag_row_t       byp_tag_reg;
    vld_row_t       byp_vld_row_reg;
    lru_row_t       byp_lru_reg;

    // Result register.
    logic                 out_vld_reg;
    logic                 out_hit_reg;
    logic [SET_IDX_W-1:0] out_set_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;

    // ------------------------------------------------------------------
    // Address split for the incoming transfer
    // ------------------------------------------------------------------
    logic [OFF_BITS_W-1:0] ob_eff;
    logic [SET_BITS_W-1:0] sb_cap;
    logic [SET_BITS_W-1:0] sb_eff;
    logic [ADDR_W-1:0]     addr_sh;
    logic [SET_IDX_W-1:0]  in_set;
    logic [4:0]            tag_sh;
    logic [TAG_W-1:0]      in_tag;
    logic [SIW-1:0]        in_row;

    always_comb
    begin
        ob_eff  = (offset_bits_reg > OFF_BITS_MAX) ? OFF_BITS_MAX : offset_bits_reg;
        sb_cap  = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_reg;
        sb_eff  = (sb_cap > SET_LIM) ? SET_LIM : sb_cap;
        addr_sh = s_tdata >> ob_eff;
        in_set  = addr_sh[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << sb_eff);
        tag_sh  = 5'(ob_eff) + 5'(sb_eff);
        in_tag  = s_tdata >> tag_sh;
        in_row  = SIW'(in_set);
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_xfer;
    logic s1_go;

    assign s1_go    = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!s1_vld_reg || s1_go);
    assign in_xfer  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Stage 1: compare, pick the way, update recency
    // ------------------------------------------------------------------
    logic [SIW-1:0] s1_row;
    logic           use_byp;
    tag_row_t       cur_tag;
    vld_row_t       cur_vld;
    lru_row_t       cur_lru;
    logic           hit;
    logic [WB-1:0]  hit_way;
    logic [WB-1:0]  lru_way;
    logic [WB-1:0]  way_sel;
    logic [WB-1:0]  pos;
    tag_row_t       new_tag;
    vld_row_t       new_vld;
    lru_row_t       new_lru;

    assign s1_row  = SIW'(s1_set_reg);
    assign use_byp = byp_vld_reg && (byp_set_reg == s1_row);

    always_comb
    begin
        cur_tag = use_byp ? byp_tag_reg     : rd_tag_reg;
        cur_vld = use_byp ? byp_vld_row_reg : rd_vld_reg;
        cur_lru = use_byp ? byp_lru_reg     : rd_lru_reg;

        // Lowest-numbered matching valid way wins.
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (cur_vld[w] && (cur_tag[w] == s1_tag_reg))
            begin
                hit     = 1'b1;
                hit_way = WB'(w);
            end
        end

        // Victim is the least recent way; a number beyond the way count
        // falls back to way zero.
        lru_way = cur_lru[WAYS-1];
        if ({1'b0, lru_way} >= (WB + 1)'(WAYS))
        begin
            lru_way = '0;
        end
        way_sel = hit ? hit_way : lru_way;

        // Position of the chosen way in the order; the last slot if absent.
        pos = WB'(WAYS - 1);
        for (int p = WAYS - 1; p >= 0; p--)
        begin
            if (cur_lru[p] == way_sel)
            begin
                pos = WB'(p);
            end
        end

        // Move the chosen way to the front, sliding the ones ahead of it back.
        new_lru    = cur_lru;
        new_lru[0] = way_sel;
        for (int p = 1; p < WAYS; p++)
        begin
            if (WB'(p) <= pos)
            begin
                new_lru[p] = cur_lru[p-1];
            end
        end

        new_tag = cur_tag;
        new_vld = cur_vld;
        if (!hit)
        begin
            new_tag[way_sel] = s1_tag_reg;
            new_vld[way_sel] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic           mem_we;
    logic [SIW-1:0] mem_wa;
    vld_row_t       mem_wvld;
    lru_row_t       mem_wlru;
    lru_row_t       dflt_lru;

    always_comb
    begin
        for (int p = 0; p < WAYS; p++)
        begin
            dflt_lru[p] = WB'(p);
        end
        mem_we   = clr_busy_reg || s1_go;
        mem_wa   = clr_busy_reg ? clr_cnt_reg : s1_row;
        mem_wvld = clr_busy_reg ? '0 : new_vld;
        mem_wlru = clr_busy_reg ? dflt_lru : new_lru;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vld_mem[mem_wa] <= mem_wvld;
            lru_mem[mem_wa] <= mem_wlru;
        end
        // Tags are never cleared: an entry is only compared once valid.
        if (s1_go)
        begin
            tag_mem[s1_row] <= new_tag;
        end
        if (in_xfer)
        begin
            rd_tag_reg <= tag_mem[in_row];
            rd_vld_reg <= vld_mem[in_row];
            rd_lru_reg <= lru_mem[in_row];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic           s1_vld_next;
    logic           out_vld_next;
    logic           byp_vld_next;
    logic           clr_busy_next;
    logic [SIW-1:0] clr_cnt_next;

    always_comb
    begin
        s1_vld_next   = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_vld_reg);
        out_vld_next  = s1_go ? 1'b1 : ((out_vld_reg && m_tready) ? 1'b0 : out_vld_reg);
        byp_vld_next  = byp_vld_reg || s1_go;
        clr_busy_next = clr_busy_reg && (clr_cnt_reg != SIW'(SETS - 1));
        clr_cnt_next  = clr_busy_reg ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFF_BITS_RESET;
            set_bits_reg    <= SET_BITS_RESET;
            s1_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            byp_vld_reg     <= 1'b0;
            clr_busy_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_wdata[OFF_BITS_W-1:0];
                    REG_SET_BITS:    set_bits_reg    <= cfg_wdata[SET_BITS_W-1:0];
                endcase
            end
            s1_vld_reg   <= s1_vld_next;
            out_vld_reg  <= out_vld_next;
            byp_vld_reg  <= byp_vld_next;
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
        if (s1_go)
        begin
            byp_set_reg     <= s1_row;
            byp_tag_reg     <= new_tag;
            byp_vld_row_reg <= new_vld;
            byp_lru_reg     <= new_lru;
            out_hit_reg     <= hit;
            out_set_reg     <= s1_set_reg;
            out_tag_reg     <= s1_tag_reg;
            out_way_reg     <= WAY_OUT_W'(way_sel);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_way_reg, out_tag_reg, out_set_reg};
    assign m_tuser  = out_hit_reg;

endmodule

// ===== rtl/salru_checker.sv =====
// Port checker for the set-associative LRU tag lookup, bound to its top level.
// Depends on salru_pkg and on set_assoc_lru_tag_lookup.
module salru_checker
    import salru_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    logic [2:0]           pend_reg;
    logic [2:0]           pend_next;
    logic                 prev_vld_reg;
    logic [37:0]          prev_key_reg;
    logic                 in_xfer;
    logic                 out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg + 3'(in_xfer) - 3'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            prev_vld_reg <= 1'b0;
            prev_key_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_xfer)
            begin
                prev_vld_reg <= 1'b1;
                prev_key_reg <= m_tdata[37:0];
            end
        end
    end

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Every result transfer answers an address already taken.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pend_reg != 3'd0)
        else $error("result without a pending address");

    // No more than the compare stage and the result register are in flight.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd2)
        else $error("too many addresses in flight");

    // A lookup repeating the previous set and tag must hit.
    a_repeat_hits: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && prev_vld_reg && (m_tdata[37:0] == prev_key_reg) |-> m_tuser)
        else $error("repeated lookup missed");

endmodule

bind set_assoc_lru_tag_lookup salru_checker u_salru_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
